// ===== design/pis_pkg.sv =====
`default_nettype none

package pis_pkg;

    // operation codes of an input request
    localparam logic [1:0] OP_ADD_FORCE = 2'd0;
    localparam logic [1:0] OP_TIME_STEP = 2'd1;
    localparam logic [1:0] OP_LOAD_POS  = 2'd2;
    localparam logic [1:0] OP_LOAD_VEL  = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_MASS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Z     = 3'd5;

    // fraction bits of dt, dt*dt/2 and drag
    localparam int unsigned DT_FRAC = 16;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               step_skipped;
    } t_out_req;

    // configuration shared by all lanes
    typedef struct packed {
        logic [30:0] recip_mass;
        logic [16:0] drag;
        logic [15:0] dt;
        logic [15:0] half_dt2;
    } t_cfg;

    // command from the top level to one lane
    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_lane_cmd;

    // command from a lane to its multiplier
    typedef struct packed {
        logic start;
        logic use_frac;
    } t_mul_ctl;

endpackage

`default_nettype wire

// ===== design/particle_integrator_step.sv =====
// Channel   Direction  Handshake                 Payload
// in        request    i_in_valid / o_in_stall   i_in_req  (t_in_req)
// out       result     o_out_valid / i_out_stall o_out_req (t_out_req)
// cfg       write      i_cfg_we                  i_cfg_index, i_cfg_data
//
// Force/load requests: T_RESULT registers the result once the output is free.
// Time step: each axis lane runs five dependent multiplies through
// its one 32x31-bit multiplier.
// A skipped step (inverse mass zero) takes the same path as a load.
// Sync active-low reset clears control, pos, vel, force; no clearing pass.
// A new request is taken once the previous result sits in the output register.
`default_nettype none

module particle_integrator_step import pis_pkg::*; #(
    parameter int unsigned WORD_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire t_in_req              i_in_req,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output t_out_req                  o_out_req,
    input  wire logic                 i_out_stall
);

    localparam int unsigned W  = WORD_WIDTH;
    localparam int unsigned YW = (W > 32) ? W : 32;
    localparam logic signed [YW-1:0] I32MAX_Y = YW'({31{1'b1}});
    localparam logic signed [YW-1:0] I32MIN_Y = ~I32MAX_Y;

    typedef enum logic [1:0] {T_IDLE, T_RUN, T_RESULT} t_tstate;

    // word value clamped to the 32-bit result range
    function automatic logic signed [31:0] clamp32(input logic signed [W-1:0] x);
        logic signed [YW-1:0] xe;
        logic signed [31:0]   y;
        xe = YW'(x);
        if (xe > I32MAX_Y) begin
            y = 32'sh7FFF_FFFF;
        end else if (xe < I32MIN_Y) begin
            y = 32'sh8000_0000;
        end else begin
            y = xe[31:0];
        end
        return y;
    endfunction

    t_tstate            r_state;
    logic               r_skip;
    logic               r_out_valid;
    t_out_req           r_out;
    logic [30:0]        r_recip_mass;
    logic [16:0]        r_drag;
    logic [15:0]        r_dt;
    logic signed [31:0] r_accel [3];

    logic               in_acc;
    logic               out_free;
    logic               is_skip;
    logic [31:0]        dt_sq;
    logic [32:0]        hdt2_sum;
    t_cfg               cfg;
    t_lane_cmd          lane_cmd;
    logic signed [31:0] lane_val [3];
    logic [2:0]         lane_done;
    logic signed [W-1:0] lane_pos [3];
    logic signed [W-1:0] lane_vel [3];
    t_out_req           n_out;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_skip  = (i_in_req.operation == OP_TIME_STEP) && (r_recip_mass == '0);

    // dt*dt/2 in Q0.16, rounded half up
    assign dt_sq    = r_dt * r_dt;
    assign hdt2_sum = {1'b0, dt_sq} + 33'(1 << DT_FRAC);

    assign cfg.recip_mass = r_recip_mass;
    assign cfg.drag       = r_drag;
    assign cfg.dt         = r_dt;
    assign cfg.half_dt2   = hdt2_sum[32:17];

    assign lane_cmd.start = in_acc && !is_skip;
    assign lane_cmd.op    = i_in_req.operation;

    assign lane_val[0] = i_in_req.value_x;
    assign lane_val[1] = i_in_req.value_y;
    assign lane_val[2] = i_in_req.value_z;

    // one lane per axis
    for (genvar g = 0; g < 3; g++) begin : g_lane
        pis_lane #(.W(W), .FRAC(FRAC_BITS)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (lane_cmd),
            .i_value (lane_val[g]),
            .i_accel (r_accel[g]),
            .i_cfg   (cfg),
            .o_done  (lane_done[g]),
            .o_pos   (lane_pos[g]),
            .o_vel   (lane_vel[g])
        );
    end

    // merge the lanes into one result
    always_comb begin
        n_out.pos_x        = clamp32(lane_pos[0]);
        n_out.pos_y        = clamp32(lane_pos[1]);
        n_out.pos_z        = clamp32(lane_pos[2]);
        n_out.vel_x        = clamp32(lane_vel[0]);
        n_out.vel_y        = clamp32(lane_vel[1]);
        n_out.vel_z        = clamp32(lane_vel[2]);
        n_out.step_skipped = r_skip;
    end

    // control, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_IDLE;
            r_skip       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_recip_mass <= 31'd65536;
            r_drag       <= 17'd65536;
            r_dt         <= 16'd1092;
            r_accel[0]   <= '0;
            r_accel[1]   <= '0;
            r_accel[2]   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_RECIP_MASS:  r_recip_mass <= i_cfg_data[30:0];
                    REG_DRAG_FACTOR: r_drag       <= i_cfg_data[16:0];
                    REG_TIME_STEP:   r_dt         <= i_cfg_data[15:0];
                    REG_ACCEL_X:     r_accel[0]   <= i_cfg_data;
                    REG_ACCEL_Y:     r_accel[1]   <= i_cfg_data;
                    REG_ACCEL_Z:     r_accel[2]   <= i_cfg_data;
                    default: ;
                endcase
            end

            // output valid: set on load from the merge, cleared once taken
            if ((r_state == T_RESULT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                T_IDLE: begin
                    if (in_acc) begin
                        r_skip <= is_skip;
                        if ((i_in_req.operation == OP_TIME_STEP) && !is_skip) begin
                            r_state <= T_RUN;
                        end else begin
                            r_state <= T_RESULT;
                        end
                    end
                end
                T_RUN: begin
                    if (&lane_done) begin
                        r_state <= T_RESULT;
                    end
                end
                T_RESULT: begin
                    if (out_free) begin
                        r_out   <= n_out;
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != T_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

`default_nettype wire

// ===== design/pis_mulq.sv =====
`default_nettype none

// Signed word times unsigned 31-bit operand, rounded half away from zero,
// saturated to the word. One 32-bit chunk of the magnitude per cycle.
module pis_mulq import pis_pkg::*; #(
    parameter int unsigned W    = 32,
    parameter int unsigned FRAC = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_mul_ctl            i_ctl,
    input  wire logic signed [W-1:0] i_a,
    input  wire logic [30:0]         i_b,
    output logic                     o_done,
    output logic signed [W-1:0]      o_res
);

    localparam int unsigned NCH = (W + 31) / 32;
    localparam int unsigned MW  = NCH * 32;
    localparam int unsigned PW  = MW + 31;
    localparam int unsigned CW  = $clog2(NCH + 1);

    localparam logic [PW:0] RND_F  = (PW+1)'(1) << (FRAC - 1);
    localparam logic [PW:0] RND_D  = (PW+1)'(1) << (DT_FRAC - 1);
    localparam logic [PW:0] WMAX_Q = (PW+1)'({(W-1){1'b1}});
    localparam logic [W-1:0] WMAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN  = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {M_IDLE, M_ACC, M_FIN} t_mstate;

    t_mstate        r_state;
    logic [MW-1:0]  r_mag;
    logic [30:0]    r_b;
    logic           r_sign;
    logic           r_frac;
    logic [PW-1:0]  r_acc;
    logic [CW-1:0]  r_cnt;
    logic           r_done;
    logic [W-1:0]   r_res;

    logic [W-1:0]   a_mag;
    logic [62:0]    pp;
    logic [PW-1:0]  n_acc;
    logic [PW:0]    rnd_sum;
    logic [PW:0]    q;
    logic [W-1:0]   n_res;

    assign a_mag = i_a[W-1] ? (~i_a + 1'b1) : i_a;

    // Horner step: shift the partial sum up one chunk and add the next
    assign pp    = r_mag[MW-1 -: 32] * r_b;
    assign n_acc = (r_acc << 32) + PW'(pp);

    // rounding, fraction drop and saturation
    always_comb begin
        rnd_sum = {1'b0, r_acc} + (r_frac ? RND_F : RND_D);
        q       = r_frac ? (rnd_sum >> FRAC) : (rnd_sum >> DT_FRAC);
        if (q > WMAX_Q) begin
            n_res = r_sign ? WMIN : WMAX;
        end else begin
            n_res = r_sign ? (~q[W-1:0] + 1'b1) : q[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            // done pulses as the result is registered
            r_done <= (r_state == M_FIN);
            unique case (r_state)
                M_IDLE: begin
                    if (i_ctl.start) begin
                        r_mag   <= MW'(a_mag);
                        r_b     <= i_b;
                        r_sign  <= i_a[W-1];
                        r_frac  <= i_ctl.use_frac;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= M_ACC;
                    end
                end
                M_ACC: begin
                    r_acc <= n_acc;
                    r_mag <= r_mag << 32;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(NCH - 1)) begin
                        r_state <= M_FIN;
                    end
                end
                M_FIN: begin
                    r_res   <= n_res;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== design/pis_lane.sv =====
`default_nettype none

// One axis: position, velocity and force accumulator with its own
// multiplier and saturating adder.
module pis_lane import pis_pkg::*; #(
    parameter int unsigned W    = 32,
    parameter int unsigned FRAC = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_lane_cmd           i_cmd,
    input  wire logic signed [31:0]  i_value,
    input  wire logic signed [31:0]  i_accel,
    input  wire t_cfg                i_cfg,
    output logic                     o_done,
    output logic signed [W-1:0]      o_pos,
    output logic signed [W-1:0]      o_vel
);

    localparam int unsigned XW = (W > 32) ? W : 32;
    localparam logic signed [XW-1:0] WMAX_X = XW'({(W-1){1'b1}});
    localparam logic signed [XW-1:0] WMIN_X = ~WMAX_X;
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {L_IDLE, L_ISSUE, L_WAIT} t_lstate;
    typedef enum logic [2:0] {
        S_VEL_DT, S_ACC_HDT2, S_FRC_INVM, S_SUM_DT, S_DRAG
    } t_step;

    // 32-bit signed input brought to the word range
    function automatic logic signed [W-1:0] sat_in(input logic signed [31:0] x);
        logic signed [XW-1:0] xe;
        logic signed [W-1:0]  y;
        xe = XW'(x);
        if (xe > WMAX_X) begin
            y = WMAX;
        end else if (xe < WMIN_X) begin
            y = WMIN;
        end else begin
            y = xe[W-1:0];
        end
        return y;
    endfunction

    t_lstate               r_state;
    t_step                 r_step;
    logic signed [W-1:0]   r_pos;
    logic signed [W-1:0]   r_vel;
    logic signed [W-1:0]   r_frc;
    logic signed [W-1:0]   r_tmp;
    logic                  r_done;

    logic signed [W-1:0]   val_w;
    logic signed [W-1:0]   acc_w;
    logic signed [W-1:0]   mul_a;
    logic [30:0]           mul_b;
    t_mul_ctl              mul_ctl;
    logic                  mul_done;
    logic signed [W-1:0]   mul_res;
    logic [W-1:0]          add_a;
    logic [W-1:0]          add_b;
    logic [W:0]            add_sum;
    logic signed [W-1:0]   add_sat;

    assign val_w = sat_in(i_value);
    assign acc_w = sat_in(i_accel);

    // operand selection for the multiplier and the adder
    always_comb begin
        mul_a = r_tmp;
        mul_b = 31'(i_cfg.drag);
        add_a = r_tmp;
        unique case (r_step)
            S_VEL_DT: begin
                mul_a = r_vel;
                mul_b = 31'(i_cfg.dt);
                add_a = r_pos;
            end
            S_ACC_HDT2: begin
                mul_a = acc_w;
                mul_b = 31'(i_cfg.half_dt2);
                add_a = r_tmp;
            end
            S_FRC_INVM: begin
                mul_a = r_frc;
                mul_b = i_cfg.recip_mass;
                add_a = acc_w;
            end
            S_SUM_DT: begin
                mul_a = r_tmp;
                mul_b = 31'(i_cfg.dt);
                add_a = r_vel;
            end
            default: begin
                mul_a = r_tmp;
                mul_b = 31'(i_cfg.drag);
                add_a = r_tmp;
            end
        endcase
        add_b = mul_res;
        if (r_state == L_IDLE) begin
            add_a = r_frc;
            add_b = val_w;
        end
    end

    // saturating add: overflow when the two top bits disagree
    assign add_sum = {add_a[W-1], add_a} + {add_b[W-1], add_b};
    assign add_sat = (add_sum[W] != add_sum[W-1]) ? (add_sum[W] ? WMIN : WMAX)
                                                   : add_sum[W-1:0];

    assign mul_ctl.start    = (r_state == L_ISSUE);
    assign mul_ctl.use_frac = (r_step == S_FRC_INVM);

    pis_mulq #(.W(W), .FRAC(FRAC)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // sequencer: one multiply per step, result folded in on completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_step  <= S_VEL_DT;
            r_pos   <= '0;
            r_vel   <= '0;
            r_frc   <= '0;
            r_done  <= 1'b0;
        end else begin
            // done pulses as the drag multiply lands
            r_done <= (r_state == L_WAIT) && mul_done && (r_step == S_DRAG);
            unique case (r_state)
                L_IDLE: begin
                    if (i_cmd.start) begin
                        unique case (i_cmd.op)
                            OP_ADD_FORCE: r_frc <= add_sat;
                            OP_LOAD_POS:  r_pos <= val_w;
                            OP_LOAD_VEL:  r_vel <= val_w;
                            default: begin
                                r_step  <= S_VEL_DT;
                                r_state <= L_ISSUE;
                            end
                        endcase
                    end
                end
                L_ISSUE: r_state <= L_WAIT;
                L_WAIT: begin
                    if (mul_done) begin
                        unique case (r_step)
                            S_VEL_DT: begin
                                r_tmp   <= add_sat;
                                r_step  <= S_ACC_HDT2;
                                r_state <= L_ISSUE;
                            end
                            S_ACC_HDT2: begin
                                r_pos   <= add_sat;
                                r_step  <= S_FRC_INVM;
                                r_state <= L_ISSUE;
                            end
                            S_FRC_INVM: begin
                                r_tmp   <= add_sat;
                                r_step  <= S_SUM_DT;
                                r_state <= L_ISSUE;
                            end
                            S_SUM_DT: begin
                                r_tmp   <= add_sat;
                                r_step  <= S_DRAG;
                                r_state <= L_ISSUE;
                            end
                            default: begin
                                r_vel   <= mul_res;
                                r_frc   <= '0;
                                r_step  <= S_VEL_DT;
                                r_state <= L_IDLE;
                            end
                        endcase
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_pos  = r_pos;
    assign o_vel  = r_vel;

endmodule

`default_nettype wire

// ===== design/pis_checker.sv =====
`default_nettype none

module pis_checker import pis_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_req  i_in_req,
    input  wire logic     o_in_stall,
    input  wire logic     o_out_valid,
    input  wire t_out_req o_out_req,
    input  wire logic     i_out_stall
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_req))
        else $error("result changed while stalled");

    // only one request in flight: an accepted request closes the input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    // a force or load request with a free output is offered after T_RESULT
    a_short_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_req.operation != OP_TIME_STEP)
            && !o_out_valid
        |=> ##1 (o_out_valid && !o_out_req.step_skipped))
        else $error("load or force result late or marked skipped");

endmodule

bind particle_integrator_step pis_checker u_pis_checker (.*);

`default_nettype wire
